// ===== src/lineb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lineb_pkg
// Shared types and constants for the line editor buffer: command codes,
// internal operation codes, render markers and the payload structs.
// ----------------------------------------------------------------------------
package lineb_pkg;

    localparam int CHAR_W = 8;
    localparam int REQ_W  = 4;
    localparam int POS_W  = 6;
    localparam int OP_W   = 4;

    // request codes as seen on the input channel
    localparam logic [REQ_W-1:0] REQ_PUT       = 4'd0;
    localparam logic [REQ_W-1:0] REQ_BACKSPACE = 4'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_TOGGLE    = 4'd3;
    localparam logic [REQ_W-1:0] REQ_LEFT      = 4'd4;
    localparam logic [REQ_W-1:0] REQ_RIGHT     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_HOME      = 4'd6;
    localparam logic [REQ_W-1:0] REQ_END       = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 4'd8;
    localparam logic [REQ_W-1:0] REQ_CLEAR_EOL = 4'd9;
    localparam logic [REQ_W-1:0] REQ_RENDER    = 4'd10;

    // internal operation codes after classification
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_PUT       = 4'd1;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 4'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 4'd3;
    localparam logic [OP_W-1:0] OP_TOGGLE    = 4'd4;
    localparam logic [OP_W-1:0] OP_LEFT      = 4'd5;
    localparam logic [OP_W-1:0] OP_RIGHT     = 4'd6;
    localparam logic [OP_W-1:0] OP_HOME      = 4'd7;
    localparam logic [OP_W-1:0] OP_END       = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 4'd9;
    localparam logic [OP_W-1:0] OP_CLEAR_EOL = 4'd10;
    localparam logic [OP_W-1:0] OP_RENDER    = 4'd11;

    localparam logic [CHAR_W-1:0] MARK_INSERT    = 8'h5F;
    localparam logic [CHAR_W-1:0] MARK_OVERWRITE = 8'h7C;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
        logic [POS_W-1:0]  length;
        logic [POS_W-1:0]  cursor;
        logic              insert_mode;
        logic              status;
    } out_t;

    // head of the command queue as handed to the execution side
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
    } qhead_t;

endpackage

// ===== src/lineb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lineb_front
// Accepts edit requests, classifies them into operation codes and holds
// them in a two-entry command queue for the execution side.
// ----------------------------------------------------------------------------
module lineb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lineb_pkg::in_t    s_data,
    output lineb_pkg::qhead_t q_head,
    input  logic              q_pop
);
    import lineb_pkg::*;

    logic [OP_W-1:0]   op_q_reg [2];
    logic [CHAR_W-1:0] ch_q_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic [OP_W-1:0]   op_dec;
    logic              push;

    always_comb begin
        case (s_data.req_type)
            REQ_PUT:       op_dec = OP_PUT;
            REQ_BACKSPACE: op_dec = OP_BACKSPACE;
            REQ_DELETE:    op_dec = OP_DELETE;
            REQ_TOGGLE:    op_dec = OP_TOGGLE;
            REQ_LEFT:      op_dec = OP_LEFT;
            REQ_RIGHT:     op_dec = OP_RIGHT;
            REQ_HOME:      op_dec = OP_HOME;
            REQ_END:       op_dec = OP_END;
            REQ_CLEAR_ALL: op_dec = OP_CLEAR_ALL;
            REQ_CLEAR_EOL: op_dec = OP_CLEAR_EOL;
            REQ_RENDER:    op_dec = OP_RENDER;
            default:       op_dec = OP_NOP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.op    = op_q_reg[rd_ptr_reg];
    assign q_head.ch    = ch_q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            op_q_reg[wr_ptr_reg] <= op_dec;
            ch_q_reg[wr_ptr_reg] <= s_data.char_code;
        end
    end

endmodule

// ===== src/lineb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lineb_back
// Executes queued edit commands on the character cells with a parallel
// shift, and on render steps through the line one character a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lineb_back #(
    parameter int LINE_MAX = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lineb_pkg::qhead_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output lineb_pkg::out_t   m_data
);
    import lineb_pkg::*;

    localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [POS_W-1:0] LMAX = POS_W'(LINE_MAX);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_RENDER = 1'b1;

    logic [CHAR_W-1:0] cell_reg [LINE_MAX];
    logic [CHAR_W-1:0] cell_next [LINE_MAX];
    logic [POS_W-1:0]  cur_reg, cur_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic              ins_reg, ins_next;
    logic              state_reg, state_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]  src_reg, src_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    logic              slot_free;
    logic              take;
    logic              status;
    logic [POS_W-1:0]  rm_pos;
    logic              do_remove;
    logic [CHAR_W-1:0] rend_char;

    assign slot_free = !out_valid_reg || m_ready;
    assign take      = (state_reg == ST_IDLE) && q_head.valid && slot_free;
    assign q_pop     = take;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    assign rend_char = (k_reg == cur_reg) ? (ins_reg ? MARK_INSERT : MARK_OVERWRITE)
                                          : cell_reg[src_reg[IDX_W-1:0]];

    always_comb begin
        cell_next      = cell_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        ins_next       = ins_reg;
        state_next     = state_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        status         = 1'b0;
        do_remove      = 1'b0;
        rm_pos         = cur_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (take) begin
            case (q_head.op)
                OP_PUT: begin
                    if (ins_reg || cur_reg >= len_reg) begin
                        if (len_reg >= LMAX) begin
                            status = 1'b1;
                        end else begin
                            for (int i = 0; i < LINE_MAX; i++) begin
                                if (POS_W'(i) > cur_reg && POS_W'(i) <= len_reg) begin
                                    cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                                end else if (POS_W'(i) == cur_reg) begin
                                    cell_next[i] = q_head.ch;
                                end
                            end
                            len_next = len_reg + 1'b1;
                            cur_next = cur_reg + 1'b1;
                        end
                    end else begin
                        for (int i = 0; i < LINE_MAX; i++) begin
                            if (POS_W'(i) == cur_reg) begin
                                cell_next[i] = q_head.ch;
                            end
                        end
                        cur_next = cur_reg + 1'b1;
                    end
                end
                OP_BACKSPACE: begin
                    if (cur_reg != '0) begin
                        do_remove = 1'b1;
                        rm_pos    = cur_reg - 1'b1;
                        cur_next  = cur_reg - 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (cur_reg < len_reg) begin
                        do_remove = 1'b1;
                    end
                end
                OP_TOGGLE:    ins_next = ~ins_reg;
                OP_LEFT: begin
                    if (cur_reg != '0) begin
                        cur_next = cur_reg - 1'b1;
                    end
                end
                OP_RIGHT: begin
                    if (cur_reg < len_reg) begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
                OP_HOME:      cur_next = '0;
                OP_END:       cur_next = len_reg;
                OP_CLEAR_ALL: begin
                    len_next = '0;
                    cur_next = '0;
                end
                OP_CLEAR_EOL: len_next = cur_reg;
                OP_RENDER: begin
                    state_next = ST_RENDER;
                    k_next     = '0;
                    src_next   = '0;
                end
                default: begin
                end
            endcase

            if (do_remove) begin
                for (int i = 0; i < LINE_MAX; i++) begin
                    if (POS_W'(i) >= rm_pos && POS_W'(i) + 1'b1 < len_reg) begin
                        cell_next[i] = cell_reg[(i + 1 < LINE_MAX) ? i + 1 : i];
                    end
                end
                len_next = len_reg - 1'b1;
            end

            if (q_head.op != OP_RENDER) begin
                out_valid_next            = 1'b1;
                out_data_next.out_char    = '0;
                out_data_next.last        = 1'b1;
                out_data_next.length      = len_next;
                out_data_next.cursor      = cur_next;
                out_data_next.insert_mode = ins_next;
                out_data_next.status      = status;
            end
        end

        if (state_reg == ST_RENDER && slot_free) begin
            out_valid_next            = 1'b1;
            out_data_next.out_char    = rend_char;
            out_data_next.last        = (k_reg == len_reg);
            out_data_next.length      = len_reg;
            out_data_next.cursor      = cur_reg;
            out_data_next.insert_mode = ins_reg;
            out_data_next.status      = 1'b0;
            k_next                    = k_reg + 1'b1;
            if (k_reg != cur_reg) begin
                src_next = src_reg + 1'b1;
            end
            if (k_reg == len_reg) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            len_reg       <= '0;
            ins_reg       <= 1'b1;
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            src_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_reg       <= cur_next;
            len_reg       <= len_next;
            ins_reg       <= ins_next;
            state_reg     <= state_next;
            k_reg         <= k_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== src/line_editor_buffer_unit.sv =====
`timescale 1ns / 1ps
// an edit's result is registered: it is valid in the cycle after the queue head is taken into the output register
// one edit per cycle while the output is not stalled and no render is running; render emits
// length + 1 results, one per cycle while the output is not stalled, paced by the character step counter
// reset: aresetn synchronous active low; cursor and length zero, insert mode,
// queue and output empty; character cells are not cleared
// ----------------------------------------------------------------------------
// line_editor_buffer_unit
// Single-line edit buffer with cursor and insert/overwrite mode: a front
// that classifies and queues commands and a back that executes them.
// ----------------------------------------------------------------------------
module line_editor_buffer_unit #(
    parameter int LINE_MAX = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lineb_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lineb_pkg::out_t m_data
);
    import lineb_pkg::*;

    qhead_t q_head;
    logic   q_pop;

    lineb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    lineb_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== src/lineb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lineb_checker
// Port-level checks for the line editor buffer, bound to the top level.
// ----------------------------------------------------------------------------
module lineb_checker #(
    parameter int LINE_MAX = 32
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input lineb_pkg::out_t m_data
);
    import lineb_pkg::*;

    localparam logic [POS_W-1:0] LMAX = POS_W'(LINE_MAX);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // cursor within line, line within store
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.length <= LMAX) && (m_data.cursor <= m_data.length))
        else $error("cursor or length out of range");

    // a dropped put only happens with a full store and is a single result
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |->
            m_data.last && (m_data.out_char == '0) && (m_data.length == LMAX))
        else $error("bad dropped-put result");

    // after reset the queue is empty and no result is pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not empty after reset");

endmodule

bind line_editor_buffer_unit lineb_checker #(
    .LINE_MAX (LINE_MAX)
) u_lineb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/tb_line_editor_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_editor_buffer_unit
// Self-checking bench for the line editor buffer. A directed table covers
// empty-line corners, both edit modes, a full line and every command. Random
// edit streams follow, with put bursts that fill the line so the full case
// keeps coming back. A built-in model of the editor predicts every result,
// and a scoreboard compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_line_editor_buffer_unit;
    import lineb_pkg::*;

    localparam int LINE_MAX   = 32;
    localparam int RAND_ITEMS = 360;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN      = 40;
    localparam int REPORT_MAX = 10;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 4'd11;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 4'd15;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
        int   reps;
    } step_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // model of the editor
    logic [CHAR_W-1:0] line_buf [LINE_MAX];
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  line_len;
    logic              ins_mode;

    out_t  results_due [$];
    step_t plan [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_count     = 0;
    int results_seen  = 0;
    int edits_sent    = 0;
    int renders_sent  = 0;
    int drops_seen    = 0;
    int full_renders  = 0;
    int quiet_cycles  = 0;
    bit running       = 1'b0;

    line_editor_buffer_unit #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_t edit_ack(logic [CHAR_W-1:0] c, logic [POS_W-1:0] len,
                                      logic [POS_W-1:0] cur, logic ins, logic st);
        return '{out_char: c, last: 1'b1, length: len, cursor: cur,
                 insert_mode: ins, status: st};
    endfunction

    task automatic add_step(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                            input int reps, input bit typed, input out_t want);
        step_t s;
        s.item  = '{req_type: req, char_code: ch};
        s.typed = typed;
        s.want  = want;
        s.reps  = reps;
        plan.push_back(s);
    endtask

    task automatic close_gap(input int pos);
        for (int i = pos; i + 1 < int'(line_len); i++) line_buf[i] = line_buf[i + 1];
        line_len = line_len - 1'b1;
    endtask

    task automatic predict_edit(input in_t item);
        logic st;
        int   src;
        int   total;
        out_t r;
        st = 1'b0;
        case (item.req_type)
            REQ_PUT: begin
                if (ins_mode || cur_pos >= line_len) begin
                    if (int'(line_len) >= LINE_MAX) begin
                        st = 1'b1;
                        drops_seen++;
                    end else begin
                        for (int i = int'(line_len); i > int'(cur_pos); i--)
                            line_buf[i] = line_buf[i - 1];
                        line_buf[cur_pos] = item.char_code;
                        line_len = line_len + 1'b1;
                        cur_pos  = cur_pos + 1'b1;
                    end
                end else begin
                    line_buf[cur_pos] = item.char_code;
                    cur_pos = cur_pos + 1'b1;
                end
            end
            REQ_BACKSPACE: begin
                if (cur_pos != 0) begin
                    close_gap(int'(cur_pos) - 1);
                    cur_pos = cur_pos - 1'b1;
                end
            end
            REQ_DELETE: if (cur_pos < line_len) close_gap(int'(cur_pos));
            REQ_TOGGLE: ins_mode = ~ins_mode;
            REQ_LEFT: if (cur_pos != 0) cur_pos = cur_pos - 1'b1;
            REQ_RIGHT: if (cur_pos < line_len) cur_pos = cur_pos + 1'b1;
            REQ_HOME: cur_pos = '0;
            REQ_END: cur_pos = line_len;
            REQ_CLEAR_ALL: begin
                line_len = '0;
                cur_pos  = '0;
            end
            REQ_CLEAR_EOL: line_len = cur_pos;
            default: ;
        endcase
        if (item.req_type == REQ_RENDER) begin
            renders_sent++;
            if (int'(line_len) == LINE_MAX) full_renders++;
            total = int'(line_len) + 1;
            src   = 0;
            for (int k = 0; k < total; k++) begin
                r = edit_ack('0, line_len, cur_pos, ins_mode, 1'b0);
                r.last = (k + 1 == total);
                if (k == int'(cur_pos)) begin
                    r.out_char = ins_mode ? MARK_INSERT : MARK_OVERWRITE;
                end else begin
                    r.out_char = line_buf[src];
                    src++;
                end
                results_due.push_back(r);
            end
        end else begin
            results_due.push_back(edit_ack('0, line_len, cur_pos, ins_mode, st));
        end
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input in_t item, input bit typed, input out_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predict_edit(item);
        if (typed) begin
            void'(results_due.pop_back());
            results_due.push_back(want);
        end
        edits_sent++;
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_count++;
            if (err_count <= REPORT_MAX)
                $display("mismatch in %s at result %0d: expected %0h, got %0h",
                         name, results_seen, want, got);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= running && ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // scoreboard: sample at the rising edge, compare once prediction has settled
    initial begin
        logic got;
        out_t seen;
        out_t want;
        forever begin
            @(posedge aclk);
            got  = aresetn && m_valid && m_ready;
            seen = m_data;
            @(negedge aclk);
            if (got) begin
                if (results_due.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result %0d: %0h", results_seen, seen);
                end else begin
                    want = results_due.pop_front();
                    check_field("out_char", int'(want.out_char), int'(seen.out_char));
                    check_field("last", int'(want.last), int'(seen.last));
                    check_field("length", int'(want.length), int'(seen.length));
                    check_field("cursor", int'(want.cursor), int'(seen.cursor));
                    check_field("insert_mode", int'(want.insert_mode),
                                int'(seen.insert_mode));
                    check_field("status", int'(want.status), int'(seen.status));
                end
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!running || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_MAX) begin
            $display("watchdog: no transfer for %0d cycles", STALL_MAX);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int   sent;
        int   n;
        int   w;
        in_t  item;
        out_t none;
        none     = '0;
        cur_pos  = '0;
        line_len = '0;
        ins_mode = 1'b1;
        for (int i = 0; i < LINE_MAX; i++) line_buf[i] = '0;

        // empty line corners
        add_step(REQ_RENDER, 8'h00, 1, 1, '{out_char: MARK_INSERT, last: 1'b1,
                 length: 6'd0, cursor: 6'd0, insert_mode: 1'b1, status: 1'b0});
        add_step(REQ_BACKSPACE, 8'hFF, 1, 1, edit_ack('0, 6'd0, 6'd0, 1'b1, 1'b0));
        add_step(REQ_DELETE, 8'h00, 1, 1, edit_ack('0, 6'd0, 6'd0, 1'b1, 1'b0));
        add_step(REQ_LEFT, 8'h00, 1, 1, edit_ack('0, 6'd0, 6'd0, 1'b1, 1'b0));
        add_step(REQ_RIGHT, 8'h00, 1, 1, edit_ack('0, 6'd0, 6'd0, 1'b1, 1'b0));
        // insert mode
        add_step(REQ_PUT, 8'h00, 1, 1, edit_ack('0, 6'd1, 6'd1, 1'b1, 1'b0));
        add_step(REQ_PUT, 8'hFF, 1, 1, edit_ack('0, 6'd2, 6'd2, 1'b1, 1'b0));
        add_step(REQ_HOME, 8'h00, 1, 1, edit_ack('0, 6'd2, 6'd0, 1'b1, 1'b0));
        add_step(REQ_PUT, 8'h41, 1, 1, edit_ack('0, 6'd3, 6'd1, 1'b1, 1'b0));
        add_step(REQ_RENDER, 8'h00, 1, 0, none);
        // overwrite mode
        add_step(REQ_TOGGLE, 8'h00, 1, 1, edit_ack('0, 6'd3, 6'd1, 1'b0, 1'b0));
        add_step(REQ_PUT, 8'h80, 1, 1, edit_ack('0, 6'd3, 6'd2, 1'b0, 1'b0));
        add_step(REQ_END, 8'h00, 1, 1, edit_ack('0, 6'd3, 6'd3, 1'b0, 1'b0));
        add_step(REQ_PUT, 8'h7F, 1, 1, edit_ack('0, 6'd4, 6'd4, 1'b0, 1'b0));
        add_step(REQ_RENDER, 8'h00, 1, 0, none);
        add_step(REQ_LEFT, 8'h00, 1, 1, edit_ack('0, 6'd4, 6'd3, 1'b0, 1'b0));
        add_step(REQ_CLEAR_EOL, 8'h00, 1, 1, edit_ack('0, 6'd3, 6'd3, 1'b0, 1'b0));
        add_step(REQ_BACKSPACE, 8'h00, 1, 1, edit_ack('0, 6'd2, 6'd2, 1'b0, 1'b0));
        add_step(REQ_HOME, 8'h00, 1, 1, edit_ack('0, 6'd2, 6'd0, 1'b0, 1'b0));
        add_step(REQ_DELETE, 8'h00, 1, 1, edit_ack('0, 6'd1, 6'd0, 1'b0, 1'b0));
        add_step(REQ_SPARE_HI, 8'hFF, 1, 1, edit_ack('0, 6'd1, 6'd0, 1'b0, 1'b0));
        add_step(REQ_SPARE_LO, 8'h00, 1, 1, edit_ack('0, 6'd1, 6'd0, 1'b0, 1'b0));
        add_step(REQ_CLEAR_ALL, 8'h00, 1, 1, edit_ack('0, 6'd0, 6'd0, 1'b0, 1'b0));
        // full line in both modes
        add_step(REQ_TOGGLE, 8'h00, 1, 1, edit_ack('0, 6'd0, 6'd0, 1'b1, 1'b0));
        add_step(REQ_PUT, 8'h61, LINE_MAX, 0, none);
        add_step(REQ_PUT, 8'h5A, 1, 1, edit_ack('0, 6'd32, 6'd32, 1'b1, 1'b1));
        add_step(REQ_RENDER, 8'h00, 1, 0, none);
        add_step(REQ_TOGGLE, 8'h00, 1, 1, edit_ack('0, 6'd32, 6'd32, 1'b0, 1'b0));
        add_step(REQ_PUT, 8'hA5, 1, 1, edit_ack('0, 6'd32, 6'd32, 1'b0, 1'b1));
        add_step(REQ_HOME, 8'h00, 1, 1, edit_ack('0, 6'd32, 6'd0, 1'b0, 1'b0));
        add_step(REQ_PUT, 8'h20, 1, 1, edit_ack('0, 6'd32, 6'd1, 1'b0, 1'b0));
        add_step(REQ_RENDER, 8'h00, 1, 0, none);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        running = 1'b1;
        src_idle_pct  = 22;
        snk_stall_pct = 77;

        foreach (plan[p]) begin
            for (int k = 0; k < plan[p].reps; k++) begin
                item = plan[p].item;
                item.char_code = item.char_code + CHAR_W'(k);
                send_item(item, plan[p].typed, plan[p].want);
            end
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent >= 2 * RAND_ITEMS / 3) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end else if (sent >= RAND_ITEMS / 3) begin
                src_idle_pct  = 77;
                snk_stall_pct = 22;
            end
            if ($urandom_range(0, 99) < 12) begin
                // burst of puts, long enough to reach a full line now and then
                n = $urandom_range(1, LINE_MAX + 4);
                for (int k = 0; k < n; k++) begin
                    item = '{req_type: REQ_PUT, char_code: CHAR_W'($urandom_range(0, 255))};
                    send_item(item, 1'b0, none);
                end
                sent += n;
            end else begin
                w = $urandom_range(0, 99);
                item.char_code = CHAR_W'($urandom_range(0, 255));
                if (w < 30)      item.req_type = REQ_PUT;
                else if (w < 38) item.req_type = REQ_BACKSPACE;
                else if (w < 46) item.req_type = REQ_DELETE;
                else if (w < 51) item.req_type = REQ_TOGGLE;
                else if (w < 58) item.req_type = REQ_LEFT;
                else if (w < 64) item.req_type = REQ_RIGHT;
                else if (w < 68) item.req_type = REQ_HOME;
                else if (w < 72) item.req_type = REQ_END;
                else if (w < 75) item.req_type = REQ_CLEAR_ALL;
                else if (w < 79) item.req_type = REQ_CLEAR_EOL;
                else if (w < 92) item.req_type = REQ_RENDER;
                else item.req_type = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
                send_item(item, 1'b0, none);
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (results_due.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);

        $display("covered %0d edit commands, %0d renders (%0d on a full line), %0d dropped puts",
                 edits_sent, renders_sent, full_renders, drops_seen);
        $display("checked %0d output transfers, %0d field mismatches",
                 results_seen, err_count);
        if (err_count == 0 && results_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
